[rtl/bba_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

    // Block header bytes in front of every user pointer
    localparam int HDR_BYTES = 16;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_LEN  = 2'd1;
    localparam logic [1:0] STAT_NO_MEM   = 2'd2;
    localparam logic [1:0] STAT_BAD_FREE = 2'd3;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [15:0] address;
        logic [15:0] length;
        logic        action;
    } t_req;

    typedef struct packed {
        logic [12:0] block_bytes;
        logic [15:0] granted_address;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_POP,
        ST_A_PAGE,
        ST_A_SPLIT,
        ST_F_TAG,
        ST_F_MERGE,
        ST_F_WALK,
        ST_F_WCHK,
        ST_F_INS,
        ST_F_INSCHK,
        ST_F_INSLINK,
        ST_F_PAGE,
        ST_RESP
    } t_state;

endpackage

[rtl/bba_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bba_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 12,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bba_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_core
// Allocator sequencer: free-list heads in flops, links, tags and the page
// stack in RAMs; walks lists one node at a time.
// ---------------------------------------------------------------------------
module bba_core #(
    parameter int POOL_PAGES      = 16,
    parameter int LEVELS          = 8,
    parameter int MIN_BLOCK_BYTES = 32,
    parameter int MAX_BLOCK_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bba_pkg::t_req i_req,
    input  logic          i_rsp_free,
    output logic          o_rsp_valid,
    output bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    localparam int UPP   = MAX_BLOCK_BYTES / MIN_BLOCK_BYTES;
    localparam int UPPL  = $clog2(UPP);
    localparam int MINL  = $clog2(MIN_BLOCK_BYTES);
    localparam int UNITS = POOL_PAGES * UPP;
    localparam int IW    = $clog2(UNITS);
    localparam int UW    = $clog2(UNITS + 1);
    localparam int LW    = $clog2(LEVELS);
    localparam int TW    = $clog2(LEVELS + 1);
    localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int PCW   = $clog2(POOL_PAGES + 1);
    localparam logic [UW-1:0] END_MARK = UW'(UNITS);
    localparam logic [LW-1:0] TOP_LV   = LW'(LEVELS - 1);

    t_state r_state, n_state;

    logic [UW-1:0]  r_heads [LEVELS];
    logic [UW-1:0]  n_heads [LEVELS];
    logic [LW-1:0]  r_lv, n_lv;
    logic [LW-1:0]  r_i, n_i;
    logic [IW-1:0]  r_b, n_b;
    logic [IW-1:0]  r_bud, n_bud;
    logic [UW-1:0]  r_cur, n_cur;
    logic [UW-1:0]  r_prev, n_prev;
    logic [PCW-1:0] r_cnt, n_cnt;
    logic [IW-1:0]  r_clr, n_clr;
    logic [POOL_PAGES-1:0] r_pvalid, n_pvalid;
    logic [PW-1:0]  r_pslot, n_pslot;
    logic           r_pslot_v, n_pslot_v;
    t_rsp           r_rsp, n_rsp;

    // memory ports
    logic           link_we, tag_we, page_we;
    logic [IW-1:0]  link_waddr, link_raddr, tag_waddr, tag_raddr;
    logic [UW-1:0]  link_wdata, link_rd;
    logic [TW-1:0]  tag_wdata, tag_rd;
    logic [PW-1:0]  page_waddr, page_raddr, page_wdata, page_rd;

    bba_ram #(.DEPTH(UNITS), .WIDTH(UW), .AW(IW)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(link_raddr), .o_rdata(link_rd)
    );
    bba_ram #(.DEPTH(UNITS), .WIDTH(TW), .AW(IW)) u_tags (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(tag_wdata),
        .i_raddr(tag_raddr), .o_rdata(tag_rd)
    );
    bba_ram #(.DEPTH(POOL_PAGES), .WIDTH(PW), .AW(PW)) u_pages (
        .i_clk(i_clk), .i_we(page_we), .i_waddr(page_waddr), .i_wdata(page_wdata),
        .i_raddr(page_raddr), .o_rdata(page_rd)
    );

    // allocate decode: size class and first non-empty larger list
    logic [16:0]   d_total;
    logic [LW-1:0] d_lv;
    logic          d_fit;
    logic          d_bad_len;
    logic [LW-1:0] d_sel;
    logic          d_found;
    always_comb begin
        d_total = {1'b0, i_req.length} + 17'(HDR_BYTES);
        d_lv    = TOP_LV;
        d_fit   = 1'b0;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if ((MIN_BLOCK_BYTES << k) >= 32'(d_total)) begin
                d_lv  = LW'(k);
                d_fit = 1'b1;
            end
        end
        d_bad_len = (i_req.length == 16'd0) ||
                    (32'(i_req.length) > MAX_BLOCK_BYTES - HDR_BYTES) || !d_fit;
        d_sel   = TOP_LV;
        d_found = 1'b0;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (LW'(k) > d_lv && r_heads[k] != END_MARK) begin
                d_sel   = LW'(k);
                d_found = 1'b1;
            end
        end
    end

    // free decode: pointer to unit index
    logic [15:0] f_start;
    logic [15:0] f_unit;
    logic        f_bad;
    always_comb begin
        f_start = i_req.address - 16'(HDR_BYTES);
        f_unit  = f_start >> MINL;
        f_bad   = (i_req.address < 16'(HDR_BYTES)) ||
                  (f_start[MINL-1:0] != '0) || (32'(f_unit) >= UNITS);
    end

    // tag check on the block being freed
    logic [LW-1:0] t_lv;
    logic          t_bad;
    always_comb begin
        t_lv  = LW'(tag_rd - TW'(1));
        t_bad = (tag_rd == '0) || (32'(tag_rd) > LEVELS) ||
                ((r_b & ((IW'(1) << t_lv) - IW'(1))) != '0);
    end

    logic [PW-1:0] a_page;
    assign a_page = r_pslot_v ? page_rd : r_pslot;

    logic in_fire;
    assign in_fire = i_req_valid && (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == IW'(UNITS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_req.action == ACT_ALLOC) begin
                        if (d_bad_len) n_state = ST_RESP;
                        else if (r_heads[d_lv] != END_MARK || d_found) n_state = ST_A_POP;
                        else if (r_cnt == '0) n_state = ST_RESP;
                        else n_state = ST_A_PAGE;
                    end else begin
                        if (i_req.address == 16'd0 || f_bad) n_state = ST_RESP;
                        else n_state = ST_F_TAG;
                    end
                end
            end
            ST_A_POP:     n_state = ST_A_SPLIT;
            ST_A_PAGE:    n_state = ST_A_SPLIT;
            ST_A_SPLIT:   if (r_i == r_lv) n_state = ST_RESP;
            ST_F_TAG:     n_state = t_bad ? ST_RESP : ST_F_MERGE;
            ST_F_MERGE:   n_state = (r_lv == TOP_LV) ? ST_F_PAGE : ST_F_WALK;
            ST_F_WALK:    n_state = (r_cur == END_MARK) ? ST_F_INS : ST_F_WCHK;
            ST_F_WCHK:    n_state = (r_cur == UW'(r_bud)) ? ST_F_MERGE : ST_F_WALK;
            ST_F_INS: begin
                if (r_cur != END_MARK && r_cur < UW'(r_b)) n_state = ST_F_INSCHK;
                else if (r_prev == END_MARK) n_state = ST_RESP;
                else n_state = ST_F_INSLINK;
            end
            ST_F_INSCHK:  n_state = ST_F_INS;
            ST_F_INSLINK: n_state = ST_RESP;
            ST_F_PAGE:    n_state = ST_RESP;
            ST_RESP:      if (i_rsp_free) n_state = ST_IDLE;
            default:      n_state = ST_CLEAR;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_heads   = r_heads;
        n_lv      = r_lv;
        n_i       = r_i;
        n_b       = r_b;
        n_bud     = r_bud;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_pvalid  = r_pvalid;
        n_pslot   = r_pslot;
        n_pslot_v = r_pslot_v;
        n_rsp     = r_rsp;
        link_we   = 1'b0;
        link_waddr = r_b;
        link_wdata = END_MARK;
        link_raddr = r_cur[IW-1:0];
        tag_we    = 1'b0;
        tag_waddr = r_b;
        tag_wdata = '0;
        tag_raddr = r_b;
        page_we   = 1'b0;
        page_waddr = r_cnt[PW-1:0];
        page_wdata = PW'(r_b >> UPPL);
        page_raddr = r_pslot;
        case (r_state)
            ST_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = r_clr;
                n_clr     = r_clr + IW'(1);
            end
            ST_IDLE: begin
                n_rsp = '0;
                if (in_fire) begin
                    if (i_req.action == ACT_ALLOC) begin
                        n_lv = d_lv;
                        if (d_bad_len) begin
                            n_rsp.status = STAT_BAD_LEN;
                        end else if (r_heads[d_lv] != END_MARK) begin
                            n_i        = d_lv;
                            n_b        = r_heads[d_lv][IW-1:0];
                            link_raddr = r_heads[d_lv][IW-1:0];
                        end else if (d_found) begin
                            n_i        = d_sel;
                            n_b        = r_heads[d_sel][IW-1:0];
                            link_raddr = r_heads[d_sel][IW-1:0];
                        end else if (r_cnt == '0) begin
                            n_rsp.status = STAT_NO_MEM;
                        end else begin
                            n_i        = TOP_LV;
                            n_cnt      = r_cnt - PCW'(1);
                            n_pslot    = PW'(r_cnt - PCW'(1));
                            n_pslot_v  = r_pvalid[PW'(r_cnt - PCW'(1))];
                            page_raddr = PW'(r_cnt - PCW'(1));
                        end
                    end else begin
                        n_b       = f_unit[IW-1:0];
                        tag_raddr = f_unit[IW-1:0];
                        if (i_req.address != 16'd0 && f_bad) n_rsp.status = STAT_BAD_FREE;
                    end
                end
            end
            // head pop lands: the list now starts at the popped block's successor
            ST_A_POP: begin
                n_heads[r_i] = link_rd;
            end
            ST_A_PAGE: begin
                n_b = IW'(a_page) << UPPL;
            end
            // split: low half heads the list below, high half goes on; tag at target
            ST_A_SPLIT: begin
                if (r_i == r_lv) begin
                    tag_we    = 1'b1;
                    tag_wdata = TW'(r_lv) + TW'(1);
                    n_rsp.status          = STAT_OK;
                    n_rsp.granted_address = 16'(({{(32-IW){1'b0}}, r_b} << MINL) + HDR_BYTES);
                    n_rsp.block_bytes     = 13'(MIN_BLOCK_BYTES << r_lv);
                end else begin
                    link_we = 1'b1;
                    n_heads[r_i - LW'(1)] = UW'(r_b);
                    n_b = r_b + (IW'(1) << (r_i - LW'(1)));
                    n_i = r_i - LW'(1);
                end
            end
            ST_F_TAG: begin
                if (t_bad) begin
                    n_rsp.status = STAT_BAD_FREE;
                end else begin
                    tag_we = 1'b1;
                    n_lv   = t_lv;
                    n_rsp.block_bytes = 13'(MIN_BLOCK_BYTES << t_lv);
                end
            end
            ST_F_MERGE: begin
                n_bud  = r_b ^ (IW'(1) << r_lv);
                n_cur  = r_heads[r_lv];
                n_prev = END_MARK;
            end
            ST_F_WALK: begin
                if (r_cur == END_MARK) begin
                    n_cur  = r_heads[r_lv];
                    n_prev = END_MARK;
                end
            end
            // buddy found: unlink it and climb one level; otherwise step to the next node
            ST_F_WCHK: begin
                if (r_cur == UW'(r_bud)) begin
                    if (r_prev == END_MARK) begin
                        n_heads[r_lv] = link_rd;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[IW-1:0];
                        link_wdata = link_rd;
                    end
                    if (r_bud < r_b) n_b = r_bud;
                    n_lv = r_lv + LW'(1);
                end else begin
                    n_prev = r_cur;
                    n_cur  = link_rd;
                end
            end
            ST_F_INS: begin
                if (!(r_cur != END_MARK && r_cur < UW'(r_b))) begin
                    link_we    = 1'b1;
                    link_wdata = r_cur;
                    if (r_prev == END_MARK) n_heads[r_lv] = UW'(r_b);
                end
            end
            ST_F_INSCHK: begin
                n_prev = r_cur;
                n_cur  = link_rd;
            end
            ST_F_INSLINK: begin
                link_we    = 1'b1;
                link_waddr = r_prev[IW-1:0];
                link_wdata = UW'(r_b);
            end
            ST_F_PAGE: begin
                if (32'(r_cnt) < POOL_PAGES) begin
                    page_we = 1'b1;
                    n_pvalid[r_cnt[PW-1:0]] = 1'b1;
                    n_cnt = r_cnt + PCW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = (r_state == ST_IDLE);
        o_rsp_valid = (r_state == ST_RESP) && i_rsp_free;
        o_rsp       = r_rsp;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_cnt    <= PCW'(POOL_PAGES);
            r_pvalid <= '0;
            for (int k = 0; k < LEVELS; k++) r_heads[k] <= END_MARK;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            r_pvalid <= n_pvalid;
            r_heads  <= n_heads;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_lv      <= n_lv;
        r_i       <= n_i;
        r_b       <= n_b;
        r_bud     <= n_bud;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_pslot   <= n_pslot;
        r_pslot_v <= n_pslot_v;
        r_rsp     <= n_rsp;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= POOL_PAGES) else $error("page count above pool size");
    a_page_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_PAGE) |-> (32'(r_cnt) < POOL_PAGES))
        else $error("page returned to a full stack");
    a_split_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_A_SPLIT) |-> (r_i >= r_lv)) else $error("split below target");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE)) else $error("request dropped");
endmodule

[rtl/buddy_block_allocator.sv]
`timescale 1ns / 1ps
// Flow, accept to result word: a length error, a null free, a bad pointer or no memory is
// answered straight from idle; a free of an untagged or misaligned block after its tag read. An allocate
// pops a list head or takes a page, then splits once per level. A free merges level by level,
// walking the list for the buddy, then inserts in address order or returns a whole page.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous active low; then a clear state writes every tag to zero before requests are taken.
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator top: request/result stream ports and result register.
// ---------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int POOL_PAGES      = 16,
    parameter int LEVELS          = 8,
    parameter int MIN_BLOCK_BYTES = 32,
    parameter int MAX_BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action[0], length[16:1], address[32:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[1:0], granted_address[17:2], block_bytes[30:18]
);
    import bba_pkg::*;

    t_req req;
    t_rsp rsp;
    logic rsp_valid;
    logic rsp_free;
    logic r_out_valid;
    t_rsp r_out;

    assign req = t_req'(s_axis_tdata[32:0]);
    assign rsp_free = !r_out_valid || m_axis_tready;

    bba_core #(
        .POOL_PAGES(POOL_PAGES), .LEVELS(LEVELS),
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES), .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready), .i_req(req),
        .i_rsp_free(rsp_free), .o_rsp_valid(rsp_valid), .o_rsp(rsp)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_free) begin
            r_out_valid <= rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_free && rsp_valid) r_out <= rsp;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};
endmodule

[tb/buddy_block_allocator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buddy_block_allocator_tb
// Drives allocate and free requests into the allocator. A local buddy model
// predicts each result word, and every result is checked field by field.
// Each random phase sets its own idle and stall rates on the two streams.
// ---------------------------------------------------------------------------
module buddy_block_allocator_tb;
    import bba_pkg::*;

    localparam int UNITS    = 2048;
    localparam int UPP      = 128;     // 32-byte units per page
    localparam int LVLS     = 8;
    localparam int PAGES    = 16;
    localparam int END_MARK = UNITS;
    localparam int LIMIT    = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_data = '0;          // action[0], length[16:1], address[32:17]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;               // status[1:0], granted_address[17:2], block_bytes[30:18]

    buddy_block_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    // model state
    int   heads [LVLS];
    int   links [UNITS];
    int   tags  [UNITS];
    int   pstack[PAGES];
    int   pcount;

    t_req req_q [$];
    t_rsp rsp_q [$];
    int   live_ptrs [$];
    t_req cur_req = '0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   stall_cnt = 0;
    bit   hold_start = 0;
    int   errors = 0;
    int   cycles = 0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // list helpers
    function automatic void push_head(int lv, int u);
        links[u] = heads[lv];
        heads[lv] = u;
    endfunction

    function automatic int pop_head(int lv);
        int u;
        u = heads[lv];
        if (u < UNITS) heads[lv] = links[u];
        return u;
    endfunction

    function automatic bit unlink_blk(int lv, int u);
        int cur, prev;
        cur = heads[lv];
        prev = END_MARK;
        while (cur < UNITS) begin
            if (cur == u) begin
                if (prev == END_MARK) heads[lv] = links[cur];
                else links[prev] = links[cur];
                return 1;
            end
            prev = cur;
            cur = links[cur];
        end
        return 0;
    endfunction

    function automatic void insert_sorted(int lv, int u);
        int cur, prev;
        cur = heads[lv];
        prev = END_MARK;
        while (cur < UNITS && cur < u) begin
            prev = cur;
            cur = links[cur];
        end
        links[u] = cur;
        if (prev == END_MARK) heads[lv] = u;
        else links[prev] = u;
    endfunction

    // buddy allocation: exact-size pop, else split larger block or a fresh page
    function automatic t_rsp alloc_blk(int len);
        t_rsp r;
        int   lv, i, b, u;
        r = '0;
        if (len == 0 || len > 4096 - HDR_BYTES) begin
            r.status = STAT_BAD_LEN;
            return r;
        end
        lv = 0;
        while (lv < LVLS - 1 && (32 << lv) < len + HDR_BYTES) lv++;
        if (heads[lv] >= UNITS) begin
            for (i = lv + 1; i < LVLS; i++)
                if (heads[i] < UNITS) break;
            if (i == LVLS) begin
                if (pcount == 0) begin
                    r.status = STAT_NO_MEM;
                    return r;
                end
                pcount--;
                push_head(LVLS - 1, pstack[pcount] * UPP);
                i = LVLS - 1;
            end
            while (i > lv) begin
                b = pop_head(i);
                push_head(i - 1, b);
                push_head(i - 1, b + (1 << (i - 1)));
                i--;
            end
        end
        u = pop_head(lv);
        tags[u] = lv + 1;
        r.status = STAT_OK;
        r.granted_address = 16'(u * 32 + HDR_BYTES);
        r.block_bytes = 13'(32 << lv);
        live_ptrs.push_back(u * 32 + HDR_BYTES);
        return r;
    endfunction

    // free with buddy merge; whole pages go back to the stack
    function automatic t_rsp free_blk(int addr);
        t_rsp r;
        int   u, lv, bud;
        r = '0;
        if (addr == 0) return r;
        r.status = STAT_BAD_FREE;
        if (addr < HDR_BYTES) return r;
        if ((addr - HDR_BYTES) % 32 != 0) return r;
        u = (addr - HDR_BYTES) / 32;
        if (u >= UNITS || tags[u] == 0) return r;
        lv = tags[u] - 1;
        if ((u & ((1 << lv) - 1)) != 0) return r;
        tags[u] = 0;
        r.status = STAT_OK;
        r.block_bytes = 13'(32 << lv);
        while (lv < LVLS - 1) begin
            bud = u ^ (1 << lv);
            if (!unlink_blk(lv, bud)) break;
            if (bud < u) u = bud;
            lv++;
        end
        if (lv == LVLS - 1) begin
            if (pcount < PAGES) begin
                pstack[pcount] = u / UPP;
                pcount++;
            end
        end else begin
            insert_sorted(lv, u);
        end
        foreach (live_ptrs[k])
            if (live_ptrs[k] == addr) begin
                live_ptrs.delete(k);
                break;
            end
        return r;
    endfunction

    // driver: present queued words, predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (cur_req.action == ACT_ALLOC) rsp_q.push_back(alloc_blk(cur_req.length));
                else rsp_q.push_back(free_blk(cur_req.address));
            end
            if (!s_valid || s_ready) begin
                if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    cur_req <= req_q[0];
                    s_data  <= {7'b0, req_q[0]};
                    s_valid <= 1'b1;
                    req_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result words, drive random and long stalls
    always @(posedge i_clk) begin
        t_rsp got, exp_r;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = t_rsp'(m_data[30:0]);
                if (rsp_q.size() == 0) begin
                    $error("result word with no expectation: %h", m_data);
                    errors++;
                end else begin
                    exp_r = rsp_q.pop_front();
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                        errors++;
                    end
                    if (got.granted_address !== exp_r.granted_address) begin
                        $error("granted_address: expected %0d, actual %0d",
                               exp_r.granted_address, got.granted_address);
                        errors++;
                    end
                    if (got.block_bytes !== exp_r.block_bytes) begin
                        $error("block_bytes: expected %0d, actual %0d",
                               exp_r.block_bytes, got.block_bytes);
                        errors++;
                    end
                end
            end
            if (hold_start) begin
                hold_start = 0;
                stall_cnt = 600;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("buddy_block_allocator test failed");
            $finish;
        end
    end

    function automatic void add_req(logic act, int len, int addr);
        t_req q;
        q.action = act;
        q.length = 16'(len);
        q.address = 16'(addr);
        req_q.push_back(q);
    endfunction

    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (req_q.size() != 0 || s_valid || rsp_q.size() != 0);
    endtask

    task automatic free_all_live();
        foreach (live_ptrs[k]) add_req(ACT_FREE, 0, live_ptrs[k]);
        drain();
    endtask

    // random mix, mostly frees of live pointers and small allocations
    task automatic gen_batch(int n, bit big);
        int r, p;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if (big) add_req(ACT_ALLOC, $urandom_range(1, 4080), $urandom);
                else if (r < 30) add_req(ACT_ALLOC, $urandom_range(1, 240), $urandom);
                else if (r < 42) add_req(ACT_ALLOC, $urandom_range(1, 4080), $urandom);
                else add_req(ACT_ALLOC, $urandom, $urandom);
            end else if (r < 88 && live_ptrs.size() > 0) begin
                p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
                if (r < 84) add_req(ACT_FREE, $urandom, p);
                else add_req(ACT_FREE, $urandom, p + 32 * $urandom_range(1, 3));
            end else begin
                add_req(ACT_FREE, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < LVLS; i++) heads[i] = END_MARK;
        for (int i = 0; i < UNITS; i++) begin
            links[i] = 0;
            tags[i] = 0;
        end
        for (int i = 0; i < PAGES; i++) pstack[i] = i;
        pcount = PAGES;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: length limits, free error cases
        add_req(ACT_ALLOC, 0, 0);
        add_req(ACT_ALLOC, 65535, 65535);
        add_req(ACT_ALLOC, 4081, 0);
        add_req(ACT_ALLOC, 1, 0);
        add_req(ACT_ALLOC, 16, 0);
        add_req(ACT_ALLOC, 17, 0);
        add_req(ACT_ALLOC, 4080, 0);
        add_req(ACT_ALLOC, 2000, 0);
        add_req(ACT_FREE, 0, 0);
        add_req(ACT_FREE, 0, 5);
        add_req(ACT_FREE, 0, 17);
        add_req(ACT_FREE, 65535, 65535);
        add_req(ACT_FREE, 0, 16 + 32 * 5);
        drain();
        free_all_live();
        // pool exhaustion
        for (int k = 0; k < 17; k++) add_req(ACT_ALLOC, 4080, 0);
        drain();
        free_all_live();

        // random phases: none but one long receiver stall, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++) begin
            send_idle = (p == 1) ? 78 : (p == 3) ? 29 : 0;
            recv_idle = (p == 2) ? 78 : (p == 3) ? 29 : 0;
            for (int b = 0; b < 10; b++) begin
                gen_batch(24, (b % 4) == 3);
                if (p == 0 && b == 2) hold_start = 1;
                drain();
            end
        end
        free_all_live();

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("buddy_block_allocator test passed");
        end else begin
            $display("buddy_block_allocator test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_core.sv
rtl/buddy_block_allocator.sv
tb/buddy_block_allocator_tb.sv
